// ===== hdl/ors_pkg.sv =====
// Shared types and constants of the ordered record slot manager.
// Used by ors_ctrl, ors_dp and ordered_record_slot_manager; depends on nothing.
package ors_pkg;

  localparam int unsigned MAX_RECORDS = 256;

  typedef enum logic [2:0] {
    OP_APPEND       = 3'd0,
    OP_INSERT_AFTER = 3'd1,
    OP_DELETE       = 3'd2,
    OP_DELETE_ALL   = 3'd3,
    OP_LOCATE       = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_POS = 2'd2
  } status_t;

  localparam logic [1:0] CFG_RECORD_BYTES = 2'd0;
  localparam logic [1:0] CFG_CAPACITY     = 2'd1;
  localparam logic [1:0] CFG_DATA_BASE    = 2'd2;

  typedef struct packed {
    logic    load;
    logic    scan_clr;
    logic    scan_inc;
    logic    take_slot;
    logic    shift_init;
    logic    shift_run;
    logic    dec_count;
    logic    commit;
    logic    rd_pos;
    logic    latch_slot;
    logic    free_slot;
    logic    clear_all;
    logic    emit;
    status_t st;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       pos_bad;
    logic       full;
    logic       scan_hit;
    logic       scan_end;
    logic       shift_done;
    logic       out_free;
  } sts_t;

endpackage

// ===== hdl/ors_ctrl.sv =====
// Controller state machine of the ordered record slot manager.
// Depends on ors_pkg; drives the command word of ors_dp from its status word.
module ors_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ors_pkg::sts_t sts,
  output ors_pkg::cmd_t cmd
);
  import ors_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CHECK  = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_SHIFT  = 8'b0000_1000,
    S_COMMIT = 8'b0001_0000,
    S_RD     = 8'b0010_0000,
    S_RDW    = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_t;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    cmd       = '0;
    cmd.st    = st_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          st_nxt    = ST_OK;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        case (sts.op) inside
          OP_APPEND, OP_INSERT_AFTER: begin
            if (sts.op == OP_INSERT_AFTER && sts.pos_bad) begin
              st_nxt    = ST_BAD_POS;
              state_nxt = S_FIN;
            end else if (sts.full) begin
              st_nxt    = ST_FULL;
              state_nxt = S_FIN;
            end else begin
              cmd.scan_clr = 1'b1;
              state_nxt    = S_SCAN;
            end
          end
          OP_DELETE, OP_LOCATE: begin
            if (sts.pos_bad) begin
              st_nxt    = ST_BAD_POS;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_RD;
            end
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          st_nxt    = ST_FULL;
          state_nxt = S_FIN;
        end else if (sts.scan_hit) begin
          cmd.take_slot  = 1'b1;
          cmd.shift_init = 1'b1;
          state_nxt      = S_SHIFT;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.shift_run = 1'b1;
        if (sts.shift_done) begin
          if (sts.op == OP_DELETE) begin
            cmd.dec_count = 1'b1;
            state_nxt     = S_FIN;
          end else begin
            state_nxt = S_COMMIT;
          end
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_FIN;
      end
      S_RD: begin
        cmd.rd_pos = 1'b1;
        state_nxt  = S_RDW;
      end
      S_RDW: begin
        cmd.latch_slot = 1'b1;
        if (sts.op == OP_DELETE) begin
          cmd.free_slot  = 1'b1;
          cmd.shift_init = 1'b1;
          state_nxt      = S_SHIFT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.clear_all = (sts.op == OP_DELETE_ALL);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

// ===== hdl/ors_dp.sv =====
// Datapath of the ordered record slot manager: configuration, order list
// memory, in-use bits, count, scan and shift counters and the result register.
// Depends on ors_pkg; steered by ors_ctrl through the command word.
module ors_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  ors_pkg::cmd_t cmd,
  output ors_pkg::sts_t sts,
  input  logic [2:0]    in_operation,
  input  logic [7:0]    in_position,
  input  logic          cfg_wr_en,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    out_status,
  output logic [7:0]    out_record_pos,
  output logic [7:0]    out_slot,
  output logic [15:0]   out_data_address,
  output logic [8:0]    out_record_count,
  output logic [8:0]    out_deleted_count
);
  import ors_pkg::*;

  localparam logic [8:0] CAP_MAX = 9'(MAX_RECORDS);

  logic [7:0]  record_bytes_r;
  logic [8:0]  capacity_r;
  logic [15:0] data_base_r;

  logic [2:0]  op_r;
  logic [7:0]  pos_r;
  logic [8:0]  count_r;
  logic [MAX_RECORDS-1:0] inuse_r;
  logic [8:0]  scan_r;
  logic [8:0]  i_r, i_nxt;
  logic [7:0]  wa_r, wa_nxt;
  logic        wv_r, wv_nxt;
  logic [7:0]  slot_r;
  logic [7:0]  rdata_r;
  logic [7:0]  list_mem [MAX_RECORDS];

  logic [8:0]  cap_eff;
  logic [8:0]  idx;
  logic [8:0]  i_inc, i_dec;
  logic        dn;
  logic        rd_en;
  logic [7:0]  raddr;
  logic        we;
  logic [7:0]  waddr, wdata;
  logic [15:0] prod;
  logic [15:0] addr_calc;
  logic        out_free;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  res_status;
  logic [7:0]  res_pos, res_slot;
  logic [15:0] res_addr;
  logic [8:0]  res_count, res_deleted;
  logic [1:0]  out_status_r;
  logic [7:0]  out_pos_r, out_slot_r;
  logic [15:0] out_addr_r;
  logic [8:0]  out_count_r, out_deleted_r;

  assign cap_eff = (capacity_r > CAP_MAX) ? CAP_MAX : capacity_r;
  assign idx     = (op_r == OP_APPEND) ? count_r : ({1'b0, pos_r} + 9'd1);
  assign i_inc   = i_r + 9'd1;
  assign i_dec   = i_r - 9'd1;
  assign dn      = (op_r == OP_DELETE);
  assign rd_en   = dn ? (i_inc < count_r) : (i_r > idx);
  assign raddr   = cmd.rd_pos ? pos_r : (dn ? i_inc[7:0] : i_dec[7:0]);
  assign out_free = !out_valid_r || !out_stall;

  assign sts.op         = op_r;
  assign sts.pos_bad    = ({1'b0, pos_r} >= count_r);
  assign sts.full       = (count_r >= cap_eff);
  assign sts.scan_hit   = !inuse_r[scan_r[7:0]];
  assign sts.scan_end   = (scan_r >= cap_eff);
  assign sts.shift_done = !rd_en && !wv_r;
  assign sts.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_bytes_r <= 8'd1;
      capacity_r     <= CAP_MAX;
      data_base_r    <= 16'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_RECORD_BYTES: record_bytes_r <= cfg_data[7:0];
        CFG_CAPACITY:     capacity_r     <= cfg_data[8:0];
        CFG_DATA_BASE:    data_base_r    <= cfg_data;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      pos_r <= in_position;
    end
    if (cmd.scan_clr) begin
      scan_r <= 9'd0;
    end else if (cmd.scan_inc) begin
      scan_r <= scan_r + 9'd1;
    end
    if (cmd.take_slot) begin
      slot_r <= scan_r[7:0];
    end else if (cmd.latch_slot) begin
      slot_r <= rdata_r;
    end
  end

  always_comb begin
    i_nxt  = i_r;
    wa_nxt = wa_r;
    wv_nxt = wv_r;
    if (cmd.shift_init) begin
      i_nxt  = dn ? {1'b0, pos_r} : count_r;
      wv_nxt = 1'b0;
    end else if (cmd.shift_run) begin
      wv_nxt = rd_en;
      if (rd_en) begin
        i_nxt  = dn ? i_inc : i_dec;
        wa_nxt = i_r[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r  <= i_nxt;
    wa_r <= wa_nxt;
    if (!rst_n) begin
      wv_r <= 1'b0;
    end else begin
      wv_r <= wv_nxt;
    end
  end

  assign we    = (cmd.shift_run && wv_r) || cmd.commit;
  assign waddr = cmd.commit ? idx[7:0] : wa_r;
  assign wdata = cmd.commit ? slot_r : rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      list_mem[waddr] <= wdata;
    end
    rdata_r <= list_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inuse_r <= '0;
      count_r <= 9'd0;
    end else begin
      if (cmd.clear_all) begin
        inuse_r <= '0;
        count_r <= 9'd0;
      end else if (cmd.commit) begin
        inuse_r[slot_r] <= 1'b1;
        count_r         <= count_r + 9'd1;
      end else if (cmd.dec_count) begin
        count_r <= count_r - 9'd1;
      end
      if (cmd.free_slot) begin
        inuse_r[rdata_r] <= 1'b0;
      end
    end
  end

  assign prod      = 16'(slot_r) * 16'(record_bytes_r);
  assign addr_calc = data_base_r + prod;

  always_comb begin
    res_status  = cmd.st;
    res_pos     = 8'd0;
    res_slot    = 8'd0;
    res_addr    = 16'd0;
    res_count   = count_r;
    res_deleted = 9'd0;
    if (cmd.st == ST_OK) begin
      case (op_r) inside
        OP_APPEND, OP_INSERT_AFTER: begin
          res_pos  = (op_r == OP_APPEND) ? 8'(count_r - 9'd1) : idx[7:0];
          res_slot = slot_r;
          res_addr = addr_calc;
        end
        OP_DELETE: begin
          res_slot = slot_r;
          res_addr = addr_calc;
        end
        OP_DELETE_ALL: begin
          res_deleted = count_r;
          res_count   = 9'd0;
        end
        OP_LOCATE: begin
          res_pos  = pos_r;
          res_slot = slot_r;
          res_addr = addr_calc;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (cmd.emit) begin
      out_status_r  <= res_status;
      out_pos_r     <= res_pos;
      out_slot_r    <= res_slot;
      out_addr_r    <= res_addr;
      out_count_r   <= res_count;
      out_deleted_r <= res_deleted;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_record_pos    = out_pos_r;
  assign out_slot          = out_slot_r;
  assign out_data_address  = out_addr_r;
  assign out_record_count  = out_count_r;
  assign out_deleted_count = out_deleted_r;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("result written while the output word is still held");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_MAX)
    else $error("record count beyond the table size");

  a_commit_inc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> count_r == $past(count_r) + 9'd1)
    else $error("commit did not raise the record count by one");

  a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.commit && cmd.shift_run))
    else $error("commit and list shift share the write port");

endmodule

// ===== hdl/ordered_record_slot_manager.sv =====
// Top level of the ordered record slot manager.
// Depends on ors_pkg, ors_ctrl and ors_dp.
//
// Usage: one input word carries an operation (append, insert after, delete,
// delete all, locate) and a logical position. It is taken at a rising edge
// where in_valid is high and in_stall is low; exactly one result word follows
// on the out_ channel, taken where out_valid is high and out_stall is low.
// The configuration port sets record size, capacity and data base; the user must
// write it only while idle, which the block does not enforce. Locate reads the
// list entry at the position; delete also frees that slot and moves the records
// above the position down; delete all and early rejections go straight to the
// result; append or insert scans the in-use bits for a free slot, moves the list
// entries above the insert point up and commits; a scan that finds no free slot
// reports full. The worst case is set by the in-use scan of one slot a cycle and
// by the list shift through the single read and write port of the list memory.
// One item is worked on at a time; in_stall is high until its result has been
// placed in the output register, and the next word is taken while that result
// still waits. A stalled receiver holds the result word unchanged; a further
// finished result then waits inside the block. Reset empties the table and
// restores the configuration defaults; the order list is not cleared.
module ordered_record_slot_manager (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [7:0]  in_position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_record_pos,
  output logic [7:0]  out_slot,
  output logic [15:0] out_data_address,
  output logic [8:0]  out_record_count,
  output logic [8:0]  out_deleted_count,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ors_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ors_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ors_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_operation      (in_operation),
    .in_position       (in_position),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_record_pos    (out_record_pos),
    .out_slot          (out_slot),
    .out_data_address  (out_data_address),
    .out_record_count  (out_record_count),
    .out_deleted_count (out_deleted_count)
  );

endmodule
